>>> design/hmseq_pkg.sv
package hmseq_pkg;

  // Default table size; the top level takes it as a parameter.
  localparam int MAX_SYMBOLS_DEF = 64;

  // Field widths fixed by the interface.
  localparam int WEIGHT_W  = 20;
  localparam int SUM_W     = 26;
  localparam int OUT_IDX_W = 6;

  // Largest stored sum; merges saturate here.
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic                last_weight;
  } in_beat_t;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] left_index;
    logic [OUT_IDX_W-1:0] right_index;
    logic [SUM_W-1:0]     merged_weight;
    logic                 last_merge;
  } out_beat_t;

endpackage

>>> design/huffman_merge_sequence_top.sv
// Huffman merge sequencer: loads weights, then emits one merge beat per step.
// Load: one weight per cycle while busy is low; a beat without last_weight is done at once.
// After the last weight, each merge beat follows a full scan: N slot reads (N = symbols loaded),
// then fold, exit and emit; N - 1 beats in all.
// Reset (rst_n low, synchronous) empties the live mask and count; weight RAM is not cleared.
// Results are single-cycle strobes on out_valid; the receiver cannot stall them.
module huffman_merge_sequence_top #(
  parameter int MAX_SYMBOLS = hmseq_pkg::MAX_SYMBOLS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  hmseq_pkg::in_beat_t  in_data,
  output logic                 out_valid,
  output hmseq_pkg::out_beat_t out_data
);

  localparam int IDX_W = $clog2(MAX_SYMBOLS);
  localparam int CNT_W = $clog2(MAX_SYMBOLS + 1);
  localparam int SUM_W = hmseq_pkg::SUM_W;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_SYMBOLS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  // control state
  logic [1:0]             state_r, state_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [MAX_SYMBOLS-1:0] live_r, live_nxt;
  logic [CNT_W-1:0]       left_r, left_nxt;     // merges still to do
  logic [CNT_W-1:0]       rd_idx_r, rd_idx_nxt; // next slot to read
  logic                   pv_r, pv_nxt;         // read data valid this cycle
  logic                   best_ok_r, best_ok_nxt;
  logic                   sec_ok_r, sec_ok_nxt;
  logic                   out_valid_r, out_valid_nxt;

  // payload state
  logic [IDX_W-1:0]       pidx_r, pidx_nxt;
  logic [IDX_W-1:0]       best_idx_r, best_idx_nxt;
  logic [IDX_W-1:0]       sec_idx_r, sec_idx_nxt;
  logic [SUM_W-1:0]       best_w_r, best_w_nxt;
  logic [SUM_W-1:0]       sec_w_r, sec_w_nxt;
  hmseq_pkg::out_beat_t   out_r, out_nxt;

  // weight RAM port
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [SUM_W-1:0] ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic [SUM_W-1:0] ram_rdata;

  logic             accept;
  logic             has_room;
  logic [CNT_W-1:0] new_count;
  logic [SUM_W:0]   sum_wide;
  logic [SUM_W-1:0] sum_sat;

  hmseq_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_SYMBOLS)
  ) u_wram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign has_room  = (count_r < CNT_FULL);
  assign new_count = has_room ? count_r + CNT_W'(1) : count_r;

  // saturating merge sum
  assign sum_wide = {1'b0, best_w_r} + {1'b0, sec_w_r};
  assign sum_sat  = sum_wide[SUM_W] ? hmseq_pkg::SUM_MAX : sum_wide[SUM_W-1:0];

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    live_nxt      = live_r;
    left_nxt      = left_r;
    rd_idx_nxt    = rd_idx_r;
    pv_nxt        = 1'b0;
    pidx_nxt      = pidx_r;
    best_ok_nxt   = best_ok_r;
    best_idx_nxt  = best_idx_r;
    best_w_nxt    = best_w_r;
    sec_ok_nxt    = sec_ok_r;
    sec_idx_nxt   = sec_idx_r;
    sec_w_nxt     = sec_w_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    ram_we        = 1'b0;
    ram_waddr     = count_r[IDX_W-1:0];
    ram_wdata     = SUM_W'(in_data.weight);
    ram_raddr     = rd_idx_r[IDX_W-1:0];

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          // full table drops the weight but still honors last_weight
          if (has_room) begin
            ram_we                          = 1'b1;
            live_nxt[count_r[IDX_W-1:0]]    = 1'b1;
          end
          count_nxt = new_count;
          if (in_data.last_weight) begin
            if (new_count > CNT_W'(1)) begin
              state_nxt   = ST_SCAN;
              left_nxt    = new_count - CNT_W'(1);
              rd_idx_nxt  = '0;
              best_ok_nxt = 1'b0;
              sec_ok_nxt  = 1'b0;
            end else begin
              // zero or one symbol: nothing to merge
              count_nxt = '0;
              live_nxt  = '0;
            end
          end
        end
      end

      ST_SCAN: begin
        // issue reads in slot order, fold each returned weight in the following cycle
        if (rd_idx_r < count_r) begin
          pv_nxt     = 1'b1;
          pidx_nxt   = rd_idx_r[IDX_W-1:0];
          rd_idx_nxt = rd_idx_r + CNT_W'(1);
        end else if (!pv_r) begin
          state_nxt = ST_EMIT;
        end
        if (pv_r && live_r[pidx_r]) begin
          if (!best_ok_r || ram_rdata < best_w_r) begin
            sec_ok_nxt   = best_ok_r;
            sec_idx_nxt  = best_idx_r;
            sec_w_nxt    = best_w_r;
            best_ok_nxt  = 1'b1;
            best_idx_nxt = pidx_r;
            best_w_nxt   = ram_rdata;
          end else if (!sec_ok_r || ram_rdata < sec_w_r) begin
            sec_ok_nxt  = 1'b1;
            sec_idx_nxt = pidx_r;
            sec_w_nxt   = ram_rdata;
          end
        end
      end

      ST_EMIT: begin
        if (best_ok_r && sec_ok_r) begin
          ram_we                   = 1'b1;
          ram_waddr                = best_idx_r;
          ram_wdata                = sum_sat;
          live_nxt[sec_idx_r]      = 1'b0;
          out_valid_nxt            = 1'b1;
          out_nxt.left_index       = hmseq_pkg::OUT_IDX_W'(best_idx_r);
          out_nxt.right_index      = hmseq_pkg::OUT_IDX_W'(sec_idx_r);
          out_nxt.merged_weight    = sum_sat;
          out_nxt.last_merge       = (left_r == CNT_W'(1));
        end
        if (left_r > CNT_W'(1) && best_ok_r && sec_ok_r) begin
          state_nxt   = ST_SCAN;
          left_nxt    = left_r - CNT_W'(1);
          rd_idx_nxt  = '0;
          best_ok_nxt = 1'b0;
          sec_ok_nxt  = 1'b0;
        end else begin
          state_nxt = ST_IDLE;
          left_nxt  = '0;
          count_nxt = '0;
          live_nxt  = '0;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      live_r      <= '0;
      left_r      <= '0;
      rd_idx_r    <= '0;
      pv_r        <= 1'b0;
      best_ok_r   <= 1'b0;
      sec_ok_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      live_r      <= live_nxt;
      left_r      <= left_nxt;
      rd_idx_r    <= rd_idx_nxt;
      pv_r        <= pv_nxt;
      best_ok_r   <= best_ok_nxt;
      sec_ok_r    <= sec_ok_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pidx_r     <= pidx_nxt;
    best_idx_r <= best_idx_nxt;
    best_w_r   <= best_w_nxt;
    sec_idx_r  <= sec_idx_nxt;
    sec_w_r    <= sec_w_nxt;
    out_r      <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

>>> design/hmseq_ram.sv
module hmseq_ram #(
  parameter int WIDTH = hmseq_pkg::SUM_W,
  parameter int DEPTH = hmseq_pkg::MAX_SYMBOLS_DEF,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> design/hmseq_checker.sv
module hmseq_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 start,
  input logic                 busy,
  input hmseq_pkg::in_beat_t  in_data,
  input logic                 out_valid,
  input hmseq_pkg::out_beat_t out_data
);

  // merge beats are spaced by at least one scan
  a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("merge beats on consecutive cycles");

  // the root beat coincides with the return to idle
  a_root_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last_merge |-> !busy)
    else $error("busy still high at root beat");

  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_merge |-> busy)
    else $error("intermediate merge beat while idle");

  // merging only starts on a last weight
  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start && in_data.last_weight))
    else $error("busy rose without a last weight");

endmodule

bind huffman_merge_sequence_top hmseq_checker u_hmseq_checker (.*);

>>> verif/huffman_merge_sequence_top_tb.sv
`timescale 1ns / 1ps

module huffman_merge_sequence_top_tb;

  localparam int SLOTS    = hmseq_pkg::MAX_SYMBOLS_DEF;
  localparam int DIR_ROWS = 19;
  localparam int SUM_W    = hmseq_pkg::SUM_W;
  localparam int WEIGHT_W = hmseq_pkg::WEIGHT_W;

  // Directed table row: one input beat, plus a hand-written merge beat for
  // two-symbol sets whose single result is obvious.
  typedef struct {
    hmseq_pkg::in_beat_t  stim;
    bit                   fixed;
    hmseq_pkg::out_beat_t want;
  } dir_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  hmseq_pkg::in_beat_t  in_data;
  logic                 out_valid;
  hmseq_pkg::out_beat_t out_data;

  // Shadow copy of the slot table used to predict the merge order.
  logic [SUM_W-1:0] slot_weight [SLOTS];
  logic [SLOTS-1:0] slot_live;
  int               sym_count;

  // Merge beats still owed by the block, oldest first.
  hmseq_pkg::out_beat_t pending_merges [$];
  int                   mismatch_count;
  int                   rand_items;
  int                   set_idx;
  int                   set_size;
  int                   idle_pct;
  hmseq_pkg::in_beat_t  beat;

  dir_row_t dir_rows [DIR_ROWS] = '{
    // single symbol: loads and clears, no merge beat
    '{{20'd5, 1'b1}, 1'b0, '0},
    // two zero weights: tie goes to the lower slot
    '{{20'd0, 1'b0}, 1'b0, '0},
    '{{20'd0, 1'b1}, 1'b1, {6'd0, 6'd1, 26'd0, 1'b1}},
    // two full-scale weights: largest possible pair sum
    '{{20'hFFFFF, 1'b0}, 1'b0, '0},
    '{{20'hFFFFF, 1'b1}, 1'b1, {6'd0, 6'd1, 26'h1FFFFE, 1'b1}},
    // smaller weight in the higher slot becomes the left side
    '{{20'd7, 1'b0}, 1'b0, '0},
    '{{20'd3, 1'b1}, 1'b1, {6'd1, 6'd0, 26'd10, 1'b1}},
    // all-equal weights: index tie-break on every merge
    '{{20'd4, 1'b0}, 1'b0, '0},
    '{{20'd4, 1'b0}, 1'b0, '0},
    '{{20'd4, 1'b0}, 1'b0, '0},
    '{{20'd4, 1'b1}, 1'b0, '0},
    // alternating bit patterns, mixed sizes
    '{{20'h55555, 1'b0}, 1'b0, '0},
    '{{20'hAAAAA, 1'b0}, 1'b0, '0},
    '{{20'd1, 1'b0}, 1'b0, '0},
    '{{20'd2, 1'b0}, 1'b0, '0},
    '{{20'd0, 1'b1}, 1'b0, '0},
    // descending weights
    '{{20'd30, 1'b0}, 1'b0, '0},
    '{{20'd20, 1'b0}, 1'b0, '0},
    '{{20'd10, 1'b1}, 1'b0, '0}
  };

  huffman_merge_sequence_top #(
    .MAX_SYMBOLS(SLOTS)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Lowest live slot holding the smallest weight, ignoring 'skip'; -1 if none.
  function automatic int lightest_slot(int skip);
    int best;
    best = -1;
    for (int k = 0; k < SLOTS; k++) begin
      if (slot_live[k] && k != skip) begin
        if (best < 0 || slot_weight[k] < slot_weight[best]) best = k;
      end
    end
    return best;
  endfunction

  // Load one weight into the shadow table; on the closing beat of a set,
  // run the whole merge loop and queue one expected beat per merge.
  task automatic predict_merges(input hmseq_pkg::in_beat_t b);
    int                   n_merges;
    int                   lo;
    int                   hi;
    logic [SUM_W:0]       total;
    hmseq_pkg::out_beat_t m;
    // weights past the table size are dropped, but last_weight still counts
    if (sym_count < SLOTS) begin
      slot_weight[sym_count] = SUM_W'(b.weight);
      slot_live[sym_count]   = 1'b1;
      sym_count++;
    end
    if (!b.last_weight) return;
    n_merges = (sym_count > 0) ? sym_count - 1 : 0;
    for (int step = 0; step < n_merges; step++) begin
      lo = lightest_slot(-1);
      hi = lightest_slot(lo);
      if (lo < 0 || hi < 0) break;
      total = {1'b0, slot_weight[lo]} + {1'b0, slot_weight[hi]};
      if (total > {1'b0, hmseq_pkg::SUM_MAX}) total = {1'b0, hmseq_pkg::SUM_MAX};
      slot_weight[lo]   = total[SUM_W-1:0];
      slot_live[hi]     = 1'b0;
      m.left_index      = hmseq_pkg::OUT_IDX_W'(lo);
      m.right_index     = hmseq_pkg::OUT_IDX_W'(hi);
      m.merged_weight   = total[SUM_W-1:0];
      m.last_merge      = (step + 1 == n_merges);
      pending_merges.push_back(m);
    end
    // block clears itself after the set
    slot_live = '0;
    sym_count = 0;
  endtask

  // Drive one beat after 'gap' idle cycles and hold it until the block takes
  // it. start is left high on return so back-to-back beats need no toggle.
  task automatic send_beat(input hmseq_pkg::in_beat_t b, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (busy !== 1'b0);
    predict_merges(b);
  endtask

  // Random weight: zeros, full scale, tiny values that force ties, and noise.
  function automatic logic [WEIGHT_W-1:0] pick_weight();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3:    return WEIGHT_W'($urandom_range(0, 3));
      default: return WEIGHT_W'($urandom);
    endcase
  endfunction

  // Merge beat checker. The receiver can't stall, so every strobe is a beat.
  always @(posedge clk) begin
    hmseq_pkg::out_beat_t exp_beat;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_merges.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("ERROR: unexpected merge beat L=%0d R=%0d W=%0d last=%0d",
                   out_data.left_index, out_data.right_index,
                   out_data.merged_weight, out_data.last_merge);
      end else begin
        exp_beat = pending_merges.pop_front();
        if (out_data.left_index !== exp_beat.left_index ||
            out_data.right_index !== exp_beat.right_index ||
            out_data.merged_weight !== exp_beat.merged_weight ||
            out_data.last_merge !== exp_beat.last_merge) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("ERROR: merge beat exp L=%0d R=%0d W=%0d last=%0d,",
                     exp_beat.left_index, exp_beat.right_index,
                     exp_beat.merged_weight, exp_beat.last_merge,
                     " got L=%0d R=%0d W=%0d last=%0d",
                     out_data.left_index, out_data.right_index,
                     out_data.merged_weight, out_data.last_merge);
        end
      end
    end
  end

  // Main stimulus: directed table, then random sets across idle phases.
  initial begin
    rst_n          = 1'b0;
    start          = 1'b0;
    in_data        = '0;
    slot_live      = '0;
    sym_count      = 0;
    mismatch_count = 0;
    rand_items     = 0;
    set_idx        = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows, back to back. Fixed rows swap the predicted beat for the
    // hand-written one; those sets give exactly one merge.
    for (int i = 0; i < DIR_ROWS; i++) begin
      send_beat(dir_rows[i].stim, 0);
      if (dir_rows[i].fixed) begin
        void'(pending_merges.pop_back());
        pending_merges.push_back(dir_rows[i].want);
      end
    end

    // Random sets. Phases rotate: no idling, sender idle 65%, sender idle 35%.
    // One oversized set fills the table and drops its tail, closing beat too.
    while (rand_items < 100) begin
      case (set_idx % 3)
        0:       idle_pct = 0;
        1:       idle_pct = 65;
        default: idle_pct = 35;
      endcase
      if (set_idx == 4)
        set_size = SLOTS + 3;
      else if ($urandom_range(0, 7) == 0)
        set_size = 1;
      else if ($urandom_range(0, 9) == 0)
        set_size = $urandom_range(9, 20);
      else
        set_size = $urandom_range(2, 8);
      for (int k = 0; k < set_size; k++) begin
        beat.weight      = pick_weight();
        beat.last_weight = (k == set_size - 1);
        send_beat(beat, ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 6) : 0);
      end
      rand_items += set_size;
      set_idx++;
    end
    start <= 1'b0;

    // Drain outstanding merges, then give the block time to settle.
    while (pending_merges.size() != 0) @(posedge clk);
    repeat (SLOTS + 8) @(posedge clk);

    if (mismatch_count == 0 && pending_merges.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run (a few dozen sets, each
  // merge a full slot scan, plus sender gaps).
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
